@@ rtl/sfdc_pkg.sv @@
// Package for the sensor frame deframer: frame byte codes and the
// CRC-16/MODBUS byte update. No dependencies.
package sfdc_pkg;

    localparam logic [7:0]  HDR0       = 8'hAA;
    localparam logic [7:0]  HDR1       = 8'h55;
    localparam logic [7:0]  TAIL       = 8'h5D;
    localparam logic [7:0]  TYPE_MEAS  = 8'h04;
    localparam logic [7:0]  TYPE_ALARM = 8'hFF;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [0:0]  KIND_MEAS  = 1'b0;
    localparam logic [0:0]  KIND_ALARM = 1'b1;

    localparam logic [2:0]  POS_TYPE   = 3'd0;
    localparam logic [2:0]  POS_TEMP_H = 3'd1;
    localparam logic [2:0]  POS_TEMP_L = 3'd2;
    localparam logic [2:0]  POS_HUM_H  = 3'd3;
    localparam logic [2:0]  POS_HUM_L  = 3'd4;
    localparam logic [2:0]  POS_CRC_H  = 3'd5;
    localparam logic [2:0]  POS_CRC_L  = 3'd6;
    localparam logic [2:0]  POS_TAIL   = 3'd7;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC after both header bytes, seeded with the initial value.
    localparam logic [15:0] CRC_AFTER_HDR = crc_byte(crc_byte(CRC_INIT, HDR0), HDR1);

endpackage

@@ rtl/sensor_frame_deframer_crc16_core.sv @@
// Top level of the sensor frame deframer with CRC-16/MODBUS check.
// Depends on sfdc_pkg for frame codes and the CRC byte update.
//
// The block takes one received byte per transaction and accepts a new byte
// in every clock cycle unless a result waits. Each byte is captured in an
// input register; the hunt, field capture and one-byte CRC update work from
// that register, and the output register holds the result once the tail byte
// is processed. A frame is 0xAA 0x55, type, temperature, humidity, CRC (all
// words big-endian) and the tail 0x5D; a frame with a good tail and CRC of
// type 0x04 yields a measurement and of type 0xFF an alarm with zero fields.
// All other frames are dropped without a rescan. Back-pressure on the result
// side stalls the input only while a finished result waits to be taken.
module sensor_frame_deframer_crc16_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_frame_kind,
    output logic signed [15:0] o_temperature,
    output logic [15:0]        o_humidity
);
    import sfdc_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_HDR   = 2'd1,
        PH_BODY  = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic [15:0] r_rcrc, n_rcrc;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [15:0] r_out_temp;
    logic [15:0] r_out_hum;

    logic        adv;
    logic        emit;
    logic        n_kind;
    logic [15:0] n_out_temp;
    logic [15:0] n_out_hum;

    assign adv        = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || adv;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_type     = r_type;
        n_temp     = r_temp;
        n_hum      = r_hum;
        n_rcrc     = r_rcrc;
        emit       = 1'b0;
        n_kind     = KIND_MEAS;
        n_out_temp = r_temp;
        n_out_hum  = r_hum;
        case (r_phase)
            PH_HDR: begin
                if (r_in_byte == HDR1) begin
                    n_phase = PH_BODY;
                    n_pos   = POS_TYPE;
                    n_crc   = CRC_AFTER_HDR;
                end else if (r_in_byte != HDR0) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_BODY: begin
                if (r_pos < POS_CRC_H) begin
                    n_crc = crc_byte(r_crc, r_in_byte);
                end
                n_pos = r_pos + 3'd1;
                case (r_pos)
                    POS_TYPE:   n_type = r_in_byte;
                    POS_TEMP_H: n_temp = {r_in_byte, 8'h00};
                    POS_TEMP_L: n_temp = {r_temp[15:8], r_in_byte};
                    POS_HUM_H:  n_hum  = {r_in_byte, 8'h00};
                    POS_HUM_L:  n_hum  = {r_hum[15:8], r_in_byte};
                    POS_CRC_H:  n_rcrc = {r_in_byte, 8'h00};
                    POS_CRC_L:  n_rcrc = {r_rcrc[15:8], r_in_byte};
                    default: begin
                        n_phase = PH_HUNT;
                        n_pos   = POS_TYPE;
                        if (r_in_byte == TAIL && r_crc == r_rcrc) begin
                            if (r_type == TYPE_MEAS) begin
                                emit = 1'b1;
                            end else if (r_type == TYPE_ALARM) begin
                                emit       = 1'b1;
                                n_kind     = KIND_ALARM;
                                n_out_temp = 16'h0000;
                                n_out_hum  = 16'h0000;
                            end
                        end
                    end
                endcase
            end
            default: begin
                n_phase = (r_in_byte == HDR0) ? PH_HDR : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_pos       <= POS_TYPE;
            r_crc       <= CRC_INIT;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (adv) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_crc   <= n_crc;
            end
            if (adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (adv) begin
            r_type <= n_type;
            r_temp <= n_temp;
            r_hum  <= n_hum;
            r_rcrc <= n_rcrc;
        end
        if (adv && emit) begin
            r_out_kind <= n_kind;
            r_out_temp <= n_out_temp;
            r_out_hum  <= n_out_hum;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_frame_kind  = r_out_kind;
    assign o_temperature = $signed(r_out_temp);
    assign o_humidity    = r_out_hum;

endmodule
